// ===== hdl/cursor_array_list_assert.svh =====
// assertion macros shared by the list design
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// condition a implies condition b in the same cycle
`define CAL_ASSERT_NOW(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// condition a implies condition b in the following cycle
`define CAL_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== hdl/cal_pkg.sv =====
package cal_pkg;

  // list geometry
  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_START        = 4'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE      = 4'd1;
  localparam logic [OP_W-1:0] OP_END          = 4'd2;
  localparam logic [OP_W-1:0] OP_INSERT_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 4'd4;
  localparam logic [OP_W-1:0] OP_APPEND       = 4'd5;
  localparam logic [OP_W-1:0] OP_INSERT       = 4'd6;
  localparam logic [OP_W-1:0] OP_ATTACH       = 4'd7;
  localparam logic [OP_W-1:0] OP_REMOVE       = 4'd8;
  localparam logic [OP_W-1:0] OP_READ         = 4'd9;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                   shift_up;
    logic                   shift_down;
    logic [IDX_W-1:0]       at;
    logic [VALUE_WIDTH-1:0] value;
  } cell_cmd_t;

  // list status after one operation
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cursor;
    logic             err;
    logic             rd_ok;
  } ctrl_res_t;

endpackage

// ===== hdl/cal_cell.sv =====
module cal_cell
  import cal_pkg::*;
(
  input  logic                   clk,
  input  logic [IDX_W-1:0]       idx,
  input  cell_cmd_t              cmd,
  input  logic [VALUE_WIDTH-1:0] prev_data,
  input  logic [VALUE_WIDTH-1:0] next_data,
  input  logic [IDX_W-1:0]       cur_sel,
  input  logic [IDX_W-1:0]       rd_sel,
  output logic [VALUE_WIDTH-1:0] data,
  output logic [VALUE_WIDTH-1:0] cur_part,
  output logic [VALUE_WIDTH-1:0] rd_part
);

  logic [VALUE_WIDTH-1:0] entry;
  logic [VALUE_WIDTH-1:0] entry_next;

  // pick from the lower neighbor, the upper neighbor, the new value or hold
  always_comb begin
    entry_next = entry;
    if (cmd.shift_up) begin
      if (idx == cmd.at) entry_next = cmd.value;
      else if (idx > cmd.at) entry_next = prev_data;
    end else if (cmd.shift_down) begin
      if (idx >= cmd.at) entry_next = next_data;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // contributions to the cursor and read selection trees
  assign data     = entry;
  assign cur_part = (cur_sel == idx) ? entry : '0;
  assign rd_part  = (rd_sel == idx) ? entry : '0;

endmodule

// ===== hdl/cal_ctrl.sv =====
module cal_ctrl
  import cal_pkg::*;
(
  input  logic [OP_W-1:0]        op,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [IDX_W-1:0]       position,
  input  logic [CNT_W-1:0]       entry_count,
  input  logic [CNT_W-1:0]       cursor_pos,
  output ctrl_res_t              res,
  output cell_cmd_t              cmd
);

  logic             item;
  logic             full;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] cursor_inc;

  assign item       = cursor_pos < entry_count;
  assign full       = entry_count >= CNT_W'(CAPACITY);
  assign count_inc  = entry_count + CNT_W'(1);
  assign count_dec  = entry_count - CNT_W'(1);
  assign cursor_inc = cursor_pos + CNT_W'(1);

  // next count and cursor, plus the shift command for the chain
  always_comb begin
    res.count      = entry_count;
    res.cursor     = cursor_pos;
    res.err        = 1'b0;
    res.rd_ok      = 1'b0;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.at         = '0;
    cmd.value      = value;
    case (op)
      OP_START: begin
        res.cursor = '0;
      end
      OP_ADVANCE: begin
        if (item) res.cursor = cursor_inc;
        else res.err = 1'b1;
      end
      OP_END: begin
        if (entry_count != '0) res.cursor = count_dec;
      end
      OP_INSERT_FRONT: begin
        if (full) begin
          res.err = 1'b1;
        end else begin
          cmd.shift_up = 1'b1;
          res.count    = count_inc;
          res.cursor   = '0;
        end
      end
      OP_REMOVE_FRONT: begin
        if (entry_count == '0) begin
          res.err = 1'b1;
        end else begin
          cmd.shift_down = 1'b1;
          res.count      = count_dec;
          res.cursor     = '0;
        end
      end
      OP_APPEND: begin
        if (full) begin
          res.err = 1'b1;
        end else begin
          cmd.shift_up = 1'b1;
          cmd.at       = entry_count[IDX_W-1:0];
          res.count    = count_inc;
          res.cursor   = entry_count;
        end
      end
      OP_INSERT: begin
        if (full) begin
          res.err = 1'b1;
        end else if (!item) begin
          // no item under the cursor: same as insert at front
          cmd.shift_up = 1'b1;
          res.count    = count_inc;
          res.cursor   = '0;
        end else begin
          cmd.shift_up = 1'b1;
          cmd.at       = cursor_pos[IDX_W-1:0];
          res.count    = count_inc;
        end
      end
      OP_ATTACH: begin
        if (full) begin
          res.err = 1'b1;
        end else if (!item) begin
          // no item under the cursor: same as append
          cmd.shift_up = 1'b1;
          cmd.at       = entry_count[IDX_W-1:0];
          res.count    = count_inc;
          res.cursor   = entry_count;
        end else begin
          cmd.shift_up = 1'b1;
          cmd.at       = cursor_inc[IDX_W-1:0];
          res.count    = count_inc;
          res.cursor   = cursor_inc;
        end
      end
      OP_REMOVE: begin
        if (!item) begin
          res.err = 1'b1;
        end else begin
          cmd.shift_down = 1'b1;
          cmd.at         = cursor_pos[IDX_W-1:0];
          res.count      = count_dec;
        end
      end
      OP_READ: begin
        if (CNT_W'(position) < entry_count) res.rd_ok = 1'b1;
        else res.err = 1'b1;
      end
      default: begin
        res.err = 1'b1;
      end
    endcase
  end

endmodule

// ===== hdl/cursor_array_list.sv =====
// channel | direction | handshake          | payload
// input   | in        | in_valid, in_stall | op, value, position
// output  | out       | out_valid, out_stall | count, cursor, has_item,
//         |           |                    | current_value, read_value, error
//
// the cell chain shifts at the accepting edge, and the result register loads
// from the cells on the next edge.
// a new item is not taken until the result register has loaded the last one.
// reset clears count, cursor and handshake state; cell contents are not cleared.
// a new item is held off while a result waits on a stalled output.
module cursor_array_list
  import cal_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        op,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [IDX_W-1:0]       position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CNT_W-1:0]       count,
  output logic [CNT_W-1:0]       cursor,
  output logic                   has_item,
  output logic [VALUE_WIDTH-1:0] current_value,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic                   error
);

  logic [CNT_W-1:0]       entry_count;
  logic [CNT_W-1:0]       cursor_pos;
  logic                   pending;
  logic                   err_q;
  logic                   rd_ok_q;
  logic [IDX_W-1:0]       pos_q;
  logic                   accept;
  logic                   item_now;
  ctrl_res_t              res;
  cell_cmd_t              cmd;
  cell_cmd_t              cmd_gated;
  logic [VALUE_WIDTH-1:0] cell_data [CAPACITY];
  logic [VALUE_WIDTH-1:0] prev_w    [CAPACITY];
  logic [VALUE_WIDTH-1:0] next_w    [CAPACITY];
  logic [VALUE_WIDTH-1:0] cur_parts [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_parts  [CAPACITY];
  logic [VALUE_WIDTH-1:0] cur_or;
  logic [VALUE_WIDTH-1:0] rd_or;

  assign in_stall = pending || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // operation decode
  cal_ctrl u_ctrl (
    .op          (op),
    .value       (value),
    .position    (position),
    .entry_count (entry_count),
    .cursor_pos  (cursor_pos),
    .res         (res),
    .cmd         (cmd)
  );

  // the chain only moves on an accepted item
  always_comb begin
    cmd_gated            = cmd;
    cmd_gated.shift_up   = cmd.shift_up && accept;
    cmd_gated.shift_down = cmd.shift_down && accept;
  end

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i] = '0;
    end else begin : g_mid
      assign prev_w[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w[i] = '0;
    end else begin : g_inner
      assign next_w[i] = cell_data[i+1];
    end

    cal_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .cmd       (cmd_gated),
      .prev_data (prev_w[i]),
      .next_data (next_w[i]),
      .cur_sel   (cursor_pos[IDX_W-1:0]),
      .rd_sel    (pos_q),
      .data      (cell_data[i]),
      .cur_part  (cur_parts[i]),
      .rd_part   (rd_parts[i])
    );
  end

  // or-trees over the selected cells
  always_comb begin
    cur_or = '0;
    rd_or  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cur_or = cur_or | cur_parts[i];
      rd_or  = rd_or | rd_parts[i];
    end
  end

  assign item_now = cursor_pos < entry_count;

  // list status and handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      cursor_pos  <= '0;
      pending     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= res.count;
        cursor_pos  <= res.cursor;
        pending     <= 1'b1;
      end else if (pending) begin
        pending <= 1'b0;
      end
      if (pending) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // per-item flags captured with the shift
  always_ff @(posedge clk) begin
    if (accept) begin
      err_q   <= res.err;
      rd_ok_q <= res.rd_ok;
      pos_q   <= position;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pending) begin
      count         <= entry_count;
      cursor        <= cursor_pos;
      has_item      <= item_now;
      current_value <= item_now ? cur_or : '0;
      read_value    <= rd_ok_q ? rd_or : '0;
      error         <= err_q;
    end
  end

  `include "cursor_array_list_assert.svh"

  `CAL_ASSERT_NOW(a_cursor_in_range, 1'b1, cursor_pos <= entry_count, "cursor past count")
  `CAL_ASSERT_NOW(a_count_in_range, 1'b1, entry_count <= CNT_W'(CAPACITY), "count past capacity")
  `CAL_ASSERT_NEXT(a_accept_pending, accept, pending && !in_stall == 1'b0, "no pending after item")
  `CAL_ASSERT_NEXT(a_pending_result, pending, out_valid && !pending, "result not presented")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import cal_pkg::*;
();

  // opcodes outside the defined set
  localparam logic [OP_W-1:0] OP_BAD_FIRST = 4'd10;
  localparam logic [OP_W-1:0] OP_BAD_LAST  = 4'd15;

  localparam int RAND_ITEMS = 1350;
  localparam int MAX_GAP    = 12;
  localparam int DRAIN_CYC  = 20;
  localparam int HOLD_CYC   = 150;

  // one list operation waiting to be sent, with the idle cycles that follow it
  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]       position;
    logic [3:0]             gap;
  } list_req_t;

  // list status expected after one operation
  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       cursor;
    logic                   has_item;
    logic [VALUE_WIDTH-1:0] cur_val;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   err;
  } list_status_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        op = OP_START;
  logic [VALUE_WIDTH-1:0] value = '0;
  logic [IDX_W-1:0]       position = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       cursor;
  logic                   has_item;
  logic [VALUE_WIDTH-1:0] current_value;
  logic [VALUE_WIDTH-1:0] read_value;
  logic                   error;

  list_req_t    op_queue[$];
  list_status_t status_q[$];

  // shadow copy of the list
  logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
  int                     list_len = 0;
  int                     cur_idx = 0;

  int          total_n = 0;
  int          sent_n = 0;
  int          fail_n = 0;
  bit          no_gaps = 1'b0;
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned result_n = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_next = 300;
  list_req_t   nxt;

  cursor_array_list dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .count         (count),
    .cursor        (cursor),
    .has_item      (has_item),
    .current_value (current_value),
    .read_value    (read_value),
    .error         (error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // open a slot at an index, shifting later entries up
  function automatic void open_slot(input int at, input logic [VALUE_WIDTH-1:0] v);
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
  endfunction

  // close the slot at an index, shifting later entries down
  function automatic void close_slot(input int at);
    for (int i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  // apply one operation to the shadow list and queue the status it yields
  function automatic void apply_list_op(input logic [OP_W-1:0] o,
                                        input logic [VALUE_WIDTH-1:0] v,
                                        input logic [IDX_W-1:0] p);
    list_status_t s;
    bit on_item;
    bit full;
    bit bad;
    logic [VALUE_WIDTH-1:0] rd;
    on_item = cur_idx < list_len;
    full = list_len >= CAPACITY;
    bad = 1'b0;
    rd = '0;
    case (o)
      OP_START: cur_idx = 0;
      OP_ADVANCE: begin
        if (on_item) cur_idx++;
        else bad = 1'b1;
      end
      OP_END: begin
        if (list_len != 0) cur_idx = list_len - 1;
      end
      OP_INSERT_FRONT: begin
        if (full) bad = 1'b1;
        else begin
          open_slot(0, v);
          cur_idx = 0;
        end
      end
      OP_REMOVE_FRONT: begin
        if (list_len == 0) bad = 1'b1;
        else begin
          close_slot(0);
          cur_idx = 0;
        end
      end
      OP_APPEND: begin
        if (full) bad = 1'b1;
        else begin
          cur_idx = list_len;
          open_slot(list_len, v);
        end
      end
      OP_INSERT: begin
        if (full) bad = 1'b1;
        else if (!on_item) begin
          open_slot(0, v);
          cur_idx = 0;
        end else open_slot(cur_idx, v);
      end
      OP_ATTACH: begin
        if (full) bad = 1'b1;
        else if (!on_item) begin
          cur_idx = list_len;
          open_slot(list_len, v);
        end else begin
          open_slot(cur_idx + 1, v);
          cur_idx++;
        end
      end
      OP_REMOVE: begin
        if (!on_item) bad = 1'b1;
        else close_slot(cur_idx);
      end
      OP_READ: begin
        if (int'(p) < list_len) rd = list_mem[p];
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    s.count    = list_len[CNT_W-1:0];
    s.cursor   = cur_idx[CNT_W-1:0];
    s.has_item = cur_idx < list_len;
    s.cur_val  = s.has_item ? list_mem[cur_idx] : '0;
    s.rd_val   = rd;
    s.err      = bad;
    status_q.push_back(s);
  endfunction

  // stimulus helpers
  function automatic void queue_op(input logic [OP_W-1:0] o,
                                   input logic [VALUE_WIDTH-1:0] v,
                                   input int p);
    list_req_t r;
    r.op = o;
    r.value = v;
    r.position = IDX_W'(p);
    r.gap = no_gaps ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
    op_queue.push_back(r);
    total_n++;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_insert_op();
    case ($urandom_range(0, 3))
      0: return OP_INSERT_FRONT;
      1: return OP_APPEND;
      2: return OP_INSERT;
      default: return OP_ATTACH;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_move_op();
    case ($urandom_range(0, 5))
      0: return OP_START;
      1: return OP_END;
      default: return OP_ADVANCE;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_remove_op();
    return ($urandom_range(0, 2) == 0) ? OP_REMOVE_FRONT : OP_REMOVE;
  endfunction

  task automatic note_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_n++;
  endtask

  task automatic compare_field(input string fld, input logic [VALUE_WIDTH-1:0] got,
                               input logic [VALUE_WIDTH-1:0] want);
    if (got !== want)
      note_failure($sformatf("result %0d %s got %0h want %0h", result_n, fld, got, want));
  endtask

  // driver: offers queued items, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_op(op, value, position);
        sent_n++;
      end
      if (!in_valid || !in_stall) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          nxt = op_queue.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op;
          value <= nxt.value;
          position <= nxt.position;
          idle_left = nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result, draws receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (status_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected", result_n));
        end else begin
          compare_field("count", VALUE_WIDTH'(count), VALUE_WIDTH'(status_q[0].count));
          compare_field("cursor", VALUE_WIDTH'(cursor), VALUE_WIDTH'(status_q[0].cursor));
          compare_field("has_item", VALUE_WIDTH'(has_item),
                        VALUE_WIDTH'(status_q[0].has_item));
          compare_field("current_value", current_value, status_q[0].cur_val);
          compare_field("read_value", read_value, status_q[0].rd_val);
          compare_field("error", VALUE_WIDTH'(error), VALUE_WIDTH'(status_q[0].err));
          void'(status_q.pop_front());
        end
        result_n++;
        // every third stretch of 97 results draws no random stalls
        stall_left = (((result_n / 97) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (hold_left != 0) || (stall_left != 0);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen = 0;
      hold_next = 300;
    end else begin
      if (out_valid === 1'b1 && !out_stall) hold_seen++;
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_seen >= hold_next) begin
        hold_left <= HOLD_CYC;
        hold_next = hold_next + 500;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int plen;
    int r;
    for (int i = 0; i < CAPACITY; i++) list_mem[i] = '0;

    // directed: empty-list refusals, cursor-less insert and attach, edges
    queue_op(OP_READ, '0, '0);
    queue_op(OP_ADVANCE, '0, '0);
    queue_op(OP_END, '0, '0);
    queue_op(OP_REMOVE_FRONT, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_BAD_LAST, '1, '1);
    queue_op(OP_INSERT, '0, '0);
    queue_op(OP_ADVANCE, '0, '0);
    queue_op(OP_ADVANCE, '0, '0);
    queue_op(OP_ATTACH, '1, '0);
    queue_op(OP_START, '0, '0);
    queue_op(OP_ATTACH, 32'hA5A5_A5A5, '0);
    queue_op(OP_INSERT, 32'h5A5A_5A5A, '0);
    queue_op(OP_INSERT_FRONT, 32'h0000_0001, '0);
    queue_op(OP_APPEND, 32'h8000_0000, '0);
    queue_op(OP_READ, '0, '1);
    queue_op(OP_READ, '0, 4);
    queue_op(OP_END, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_REMOVE_FRONT, '0, '0);
    queue_op(OP_START, '0, '0);
    queue_op(OP_REMOVE, '0, '0);
    queue_op(OP_BAD_FIRST, '0, '0);

    // random phases: grow, shrink, fill past capacity, mixed
    while (total_n < RAND_ITEMS + 24) begin
      kind = $urandom_range(0, 9);
      plen = (kind == 5) ? 45 : $urandom_range(10, 40);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < plen; k++) begin
        r = $urandom_range(0, 99);
        if (kind <= 2) begin
          if (r < 60) queue_op(rand_insert_op(), rand_value(), $urandom_range(0, 31));
          else if (r < 80) queue_op(rand_move_op(), rand_value(), $urandom_range(0, 31));
          else if (r < 90) queue_op(OP_READ, rand_value(), $urandom_range(0, 31));
          else queue_op(rand_remove_op(), rand_value(), $urandom_range(0, 31));
        end else if (kind <= 4) begin
          if (r < 55) queue_op(rand_remove_op(), rand_value(), $urandom_range(0, 31));
          else if (r < 75) queue_op(rand_move_op(), rand_value(), $urandom_range(0, 31));
          else if (r < 90) queue_op(OP_READ, rand_value(), $urandom_range(0, 31));
          else queue_op(rand_insert_op(), rand_value(), $urandom_range(0, 31));
        end else if (kind == 5) begin
          if (r < 85) queue_op(rand_insert_op(), rand_value(), $urandom_range(0, 31));
          else queue_op(OP_READ, rand_value(), $urandom_range(0, 31));
        end else begin
          if (r < 95) queue_op(OP_W'($urandom_range(OP_START, OP_READ)), rand_value(),
                               $urandom_range(0, 31));
          else queue_op(OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)), rand_value(),
                        $urandom_range(0, 31));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sent_n != total_n || status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_n == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cal_pkg.sv
hdl/cal_cell.sv
hdl/cal_ctrl.sv
hdl/cursor_array_list.sv
tb/tb_top.sv
